@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, suspended while reset is asserted
`define TPDC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, suspended while reset is asserted
`define TPDC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Same-cycle implication that also holds across reset
`define TPDC_ASSERT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/tpdc_pkg.sv @@
// Types and constants for the TCP port duplication classifier
`timescale 1ns / 1ps

package tpdc_pkg;

    localparam int unsigned MAX_COPIES = 8;

    localparam logic [15:0] ETH_IPV4      = 16'h0800;
    localparam logic [15:0] ETH_IPV6      = 16'h86DD;
    localparam logic [7:0]  IHL_MASK      = 8'h0F;
    localparam logic [5:0]  IPV6_HDR_LEN  = 6'd40;
    localparam logic [6:0]  IPV4_PROTO_POS = 7'd9;
    localparam logic [6:0]  IPV6_NXT_POS  = 7'd6;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [6:0]  POS_SAT       = 7'd64;
    localparam logic [7:0]  LINK_STATE_LOSSY = 8'd1;
    localparam logic [6:0]  DPORT_HI_OFS  = 7'd2;
    localparam logic [6:0]  DPORT_LO_OFS  = 7'd3;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_V4   = 2'd1,
        KIND_V6   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        REG_TARGET_IF = 2'd0,
        REG_PORT_LOW  = 2'd1,
        REG_PORT_HIGH = 2'd2,
        REG_COPY_MULT = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] target_if;
        logic [15:0] port_low;
        logic [15:0] port_high;
        logic [7:0]  copy_mult;
    } t_cfg;

    typedef struct packed {
        logic [6:0]  pos;
        logic [5:0]  hdr_len;
        t_kind       kind;
        logic        lossy;
        logic        tcp_seen;
        logic [15:0] port;
        logic [1:0]  port_seen;
    } t_hdr_state;

endpackage

@@ hw/rtl/tcp_port_duplication_classifier_top.sv @@
// Top level of the TCP port duplication classifier
`timescale 1ns / 1ps

// Usage
// Input channel (i_valid / o_ready) carries one packet byte per word, starting
// at the IP header, with first/last flags; EtherType and link state are
// sampled with the first byte. The output channel (o_valid / i_ready) gives
// one word per packet, on its last byte: total copies and clone interface.
// Throughput: one byte per cycle, sustained; only a last byte waits on a full
// result register.
// Path: a last byte goes into the input register, then the header update and
// copy decision load the result register. Bytes that are not last produce nothing.
// Stall: while the result register is full and not taken, a last byte holds
// in the input register and o_ready drops; other bytes keep flowing.
// Reset (i_rst_n low, synchronous): both registers empty, capture state set
// to "not IP", registers back to defaults (copy multiplier one).
// Configuration goes through the APB port and must be written only while idle; the block does not enforce this.

module tcp_port_duplication_classifier_top #(
    parameter int unsigned MAX_COPIES = tpdc_pkg::MAX_COPIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    input  logic [15:0] i_ether_type,
    input  logic [7:0]  i_link_state,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_total_copies,
    output logic [31:0] o_clone_interface,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                 r_in_valid;
    logic [7:0]           r_in_data;
    logic                 r_in_first;
    logic                 r_in_last;
    logic [15:0]          r_in_etype;
    logic [7:0]           r_in_link;
    logic                 r_out_valid;
    logic [3:0]           r_out_copies;
    logic [31:0]          r_out_if;
    logic                 w_adv;
    logic [3:0]           w_copies;
    tpdc_pkg::t_cfg       w_cfg;
    tpdc_pkg::t_hdr_state w_next;

    // advance the held word unless it is a last word blocked by a full output
    assign w_adv   = r_in_valid & (~r_in_last | ~r_out_valid | i_ready);
    assign o_ready = ~r_in_valid | w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_in_data  <= i_data_byte;
            r_in_first <= i_first_byte;
            r_in_last  <= i_last_byte;
            r_in_etype <= i_ether_type;
            r_in_link  <= i_link_state;
        end
    end

    tpdc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tpdc_hdr_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_data_byte  (r_in_data),
        .i_first_byte (r_in_first),
        .i_ether_type (r_in_etype),
        .i_link_state (r_in_link),
        .o_next       (w_next)
    );

    tpdc_copy_calc #(
        .MAX_COPIES (MAX_COPIES)
    ) u_calc (
        .i_state        (w_next),
        .i_cfg          (w_cfg),
        .o_total_copies (w_copies)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_last) begin
            r_out_copies <= w_copies;
            r_out_if     <= w_cfg.target_if;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_total_copies    = r_out_copies;
    assign o_clone_interface = r_out_if;

endmodule

@@ hw/rtl/tpdc_cfg_regs.sv @@
// APB configuration registers of the classifier
`timescale 1ns / 1ps

module tpdc_cfg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output tpdc_pkg::t_cfg      o_cfg
);

    tpdc_pkg::t_cfg     r_cfg;
    tpdc_pkg::t_reg_idx w_idx;
    logic               w_wr;

    assign w_idx  = tpdc_pkg::t_reg_idx'(paddr[3:2]);
    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_if <= '0;
            r_cfg.port_low  <= '0;
            r_cfg.port_high <= '0;
            r_cfg.copy_mult <= 8'd1;
        end else if (w_wr) begin
            case (w_idx)
                tpdc_pkg::REG_TARGET_IF: r_cfg.target_if <= pwdata;
                tpdc_pkg::REG_PORT_LOW:  r_cfg.port_low  <= pwdata[15:0];
                tpdc_pkg::REG_PORT_HIGH: r_cfg.port_high <= pwdata[15:0];
                tpdc_pkg::REG_COPY_MULT: r_cfg.copy_mult <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            tpdc_pkg::REG_TARGET_IF: prdata = r_cfg.target_if;
            tpdc_pkg::REG_PORT_LOW:  prdata = {16'd0, r_cfg.port_low};
            tpdc_pkg::REG_PORT_HIGH: prdata = {16'd0, r_cfg.port_high};
            tpdc_pkg::REG_COPY_MULT: prdata = {24'd0, r_cfg.copy_mult};
            default:                 prdata = '0;
        endcase
    end

endmodule

@@ hw/rtl/tpdc_hdr_parser.sv @@
// Header capture state: packet kind, header length, protocol and destination port
`timescale 1ns / 1ps

module tpdc_hdr_parser (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_first_byte,
    input  logic [15:0]            i_ether_type,
    input  logic [7:0]             i_link_state,
    output tpdc_pkg::t_hdr_state   o_next
);

    tpdc_pkg::t_hdr_state r_state;
    tpdc_pkg::t_hdr_state w_base;
    tpdc_pkg::t_hdr_state n_state;
    logic [6:0]           w_hi_pos;
    logic [6:0]           w_lo_pos;

    // Start of packet: clear capture, latch kind and link state, and set the IPv6 header length
    always_comb begin
        w_base = r_state;
        if (i_first_byte) begin
            w_base       = '0;
            w_base.lossy = (i_link_state == tpdc_pkg::LINK_STATE_LOSSY);
            if (i_ether_type == tpdc_pkg::ETH_IPV4) begin
                w_base.kind = tpdc_pkg::KIND_V4;
            end else if (i_ether_type == tpdc_pkg::ETH_IPV6) begin
                w_base.kind    = tpdc_pkg::KIND_V6;
                w_base.hdr_len = tpdc_pkg::IPV6_HDR_LEN;
            end else begin
                w_base.kind = tpdc_pkg::KIND_NONE;
            end
        end
    end

    always_comb begin
        n_state = w_base;
        case (w_base.kind)
            tpdc_pkg::KIND_V4: begin
                if (w_base.pos == '0) begin
                    n_state.hdr_len = {(i_data_byte[3:0] & tpdc_pkg::IHL_MASK[3:0]), 2'b00};
                end
                if (w_base.pos == tpdc_pkg::IPV4_PROTO_POS) begin
                    n_state.tcp_seen = (i_data_byte == tpdc_pkg::PROTO_TCP);
                end
            end
            tpdc_pkg::KIND_V6: begin
                if (w_base.pos == tpdc_pkg::IPV6_NXT_POS) begin
                    n_state.tcp_seen = (i_data_byte == tpdc_pkg::PROTO_TCP);
                end
            end
            default: ;
        endcase
        // port offsets follow the header length just taken
        w_hi_pos = {1'b0, n_state.hdr_len} + tpdc_pkg::DPORT_HI_OFS;
        w_lo_pos = {1'b0, n_state.hdr_len} + tpdc_pkg::DPORT_LO_OFS;
        if (w_base.kind != tpdc_pkg::KIND_NONE && w_base.pos < tpdc_pkg::POS_SAT) begin
            if (w_base.pos == w_hi_pos) begin
                n_state.port[15:8]   = i_data_byte;
                n_state.port_seen[1] = 1'b1;
            end else if (w_base.pos == w_lo_pos) begin
                n_state.port[7:0]    = i_data_byte;
                n_state.port_seen[0] = 1'b1;
            end
        end
        if (w_base.pos < tpdc_pkg::POS_SAT) begin
            n_state.pos = w_base.pos + 7'd1;
        end
    end

    assign o_next = n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_adv) begin
            r_state <= n_state;
        end
    end

endmodule

@@ hw/rtl/tpdc_copy_calc.sv @@
// Copy count decision from captured header state and configuration
`timescale 1ns / 1ps

module tpdc_copy_calc #(
    parameter int unsigned MAX_COPIES = tpdc_pkg::MAX_COPIES
) (
    input  tpdc_pkg::t_hdr_state i_state,
    input  tpdc_pkg::t_cfg       i_cfg,
    output logic [3:0]           o_total_copies
);

    logic       w_dup;
    logic       w_port_ok;
    logic [7:0] w_mult;

    always_comb begin
        w_port_ok = 1'b1;
        if (i_cfg.port_low != '0) begin
            w_port_ok = (i_state.port_seen == 2'b11) &&
                        (i_state.port >= i_cfg.port_low) &&
                        (i_state.port <= i_cfg.port_high);
        end
        w_dup = i_state.lossy && (i_cfg.target_if != '0) &&
                (i_state.kind != tpdc_pkg::KIND_NONE) && i_state.tcp_seen && w_port_ok;

        // zero means one, clamp to the maximum
        w_mult = (i_cfg.copy_mult == '0) ? 8'd1 : i_cfg.copy_mult;
        if (w_mult > 8'(MAX_COPIES)) begin
            w_mult = 8'(MAX_COPIES);
        end
        o_total_copies = w_dup ? w_mult[3:0] : 4'd1;
    end

endmodule

@@ hw/rtl/tpdc_checker.sv @@
// Port-level checker for the classifier, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tpdc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [3:0]  o_total_copies,
    input logic [31:0] o_clone_interface
);

    // a stalled result word holds its payload
    `TPDC_ASSERT_NXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_total_copies) && $stable(o_clone_interface))

    // no duplication without a target interface
    `TPDC_ASSERT_IMP(a_no_if_single, o_valid && o_clone_interface == 32'd0, o_total_copies == 4'd1)

    // a new result follows an accepted word through the input and result registers
    `TPDC_ASSERT_IMP(a_out_latency, $rose(o_valid), $past(i_valid && o_ready, 2))

    // reset empties the result register
    `TPDC_ASSERT_ALWAYS(a_reset_empty, $past(!i_rst_n), !o_valid)

endmodule

bind tcp_port_duplication_classifier_top tpdc_checker u_tpdc_checker (.*);
